/* rtl/sdar_pkg.sv */
// ---------------------------------------------------------------------------
// sdar_pkg: shared types and constants for the switch debouncer
// Payload structs, configuration register map and the saturating tick counter.
// ---------------------------------------------------------------------------
package sdar_pkg;

  localparam int SW_MAX    = 8;
  localparam int SW_IDX_W  = 3;
  localparam int CNT_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESS_DELAY   = 3'd0,
    CFG_REARM_DELAY   = 3'd1,
    CFG_REPEAT_DELAY  = 3'd2,
    CFG_LONG_HOLD     = 3'd3,
    CFG_SPECIAL_INDEX = 3'd4,
    CFG_REPEAT_MASK   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [SW_MAX-1:0] level_low;
    logic [SW_MAX-1:0] fall_events;
    logic [SW_MAX-1:0] press_ack;
  } in_item_t;

  typedef struct packed {
    logic [SW_MAX-1:0] pressed;
    logic              long_hold_event;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]    press_delay;
    logic [CNT_W-1:0]    rearm_delay;
    logic [CNT_W-1:0]    repeat_delay;
    logic [CNT_W-1:0]    long_hold;
    logic [SW_IDX_W-1:0] special_index;
    logic [SW_MAX-1:0]   repeat_mask;
  } cfg_regs_t;

  // per-switch role, decoded from the configuration
  typedef struct packed {
    logic is_special;
    logic is_repeat;
  } lane_ctrl_t;

  // per-switch result of one tick
  typedef struct packed {
    logic pressed;
    logic long_hold_event;
  } lane_res_t;

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    count_up = (c == COUNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

/* rtl/switch_debouncer_autorepeat.sv */
// ---------------------------------------------------------------------------
// switch_debouncer_autorepeat: push-button debouncer with auto-repeat
// Each input transfer is one debounce tick carrying the live low levels, the
// press edges since the last tick and acknowledges of reported presses.
// Each tick gives one result: the pending press bitmap and a long-hold event
// for the special switch.
// Configuration is written over the cfg_ channel (always ready) by register
// index; unknown indexes are ignored. Write it only while the block is idle.
// Path: a tick accepted goes into the input register, and its result is then
// registered at out_ when the result slot is free.
// Throughput: one tick per cycle while the output does not stall, set by the
// single-pass per-switch logic between the input and result registers.
// Reset clears all switch state and loads the default delays 5, 35, 75, 300,
// special index 0 and an empty repeat mask.
// When out_ready is low the result holds, the input register keeps one more
// tick and in_ready drops once both are full.
// ---------------------------------------------------------------------------
module switch_debouncer_autorepeat
  import sdar_pkg::*;
#(
  parameter int SWITCH_COUNT = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_regs_t cfg_r;
  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      adv;
  out_item_t res_nxt;
  lane_res_t lane_res [SW_MAX];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_delay   <= CNT_W'(5);
      cfg_r.rearm_delay   <= CNT_W'(35);
      cfg_r.repeat_delay  <= CNT_W'(75);
      cfg_r.long_hold     <= CNT_W'(300);
      cfg_r.special_index <= '0;
      cfg_r.repeat_mask   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PRESS_DELAY:   cfg_r.press_delay   <= cfg_data;
        CFG_REARM_DELAY:   cfg_r.rearm_delay   <= cfg_data;
        CFG_REPEAT_DELAY:  cfg_r.repeat_delay  <= cfg_data;
        CFG_LONG_HOLD:     cfg_r.long_hold     <= cfg_data;
        CFG_SPECIAL_INDEX: cfg_r.special_index <= cfg_data[SW_IDX_W-1:0];
        CFG_REPEAT_MASK:   cfg_r.repeat_mask   <= cfg_data[SW_MAX-1:0];
        default: ;
      endcase
    end
  end

  // the tick in the input register moves on when the result slot is free
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (adv && s1_valid_r) begin
      out_data_r <= res_nxt;
    end
  end

  for (genvar i = 0; i < SW_MAX; i++) begin : g_sw
    if (i < SWITCH_COUNT) begin : g_live
      lane_ctrl_t ctrl;
      assign ctrl.is_special = (cfg_r.special_index == SW_IDX_W'(i));
      assign ctrl.is_repeat  = cfg_r.repeat_mask[i];
      sdar_lane u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .upd     (adv && s1_valid_r),
        .cfg     (cfg_r),
        .ctrl    (ctrl),
        .low     (s1_data_r.level_low[i]),
        .fall    (s1_data_r.fall_events[i]),
        .ack     (s1_data_r.press_ack[i]),
        .res_nxt (lane_res[i])
      );
    end else begin : g_unused
      assign lane_res[i] = '0;
    end
  end

  always_comb begin
    res_nxt = '0;
    for (int k = 0; k < SW_MAX; k++) begin
      res_nxt.pressed[k]      = lane_res[k].pressed;
      res_nxt.long_hold_event = res_nxt.long_hold_event | lane_res[k].long_hold_event;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a long-hold event needs a special switch that exists
  a_event_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.long_hold_event |->
      (int'(cfg_r.special_index) < SWITCH_COUNT))
    else $error("long-hold event without a live special switch");

  // switches beyond SWITCH_COUNT never report a press
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.pressed >> SWITCH_COUNT) == '0))
    else $error("press reported on an unused switch");

  // a tick waiting in the input register is kept while the result stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_data_r))
    else $error("input register lost a stalled tick");

  // a result that stalls is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed");

endmodule

/* rtl/sdar_lane.sv */
// ---------------------------------------------------------------------------
// sdar_lane: one switch of the debouncer
// Holds the held, debounce and pressed flags and the hold counter of one
// switch and advances them by one tick when upd is high.
// ---------------------------------------------------------------------------
module sdar_lane
  import sdar_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       upd,
  input  cfg_regs_t  cfg,
  input  lane_ctrl_t ctrl,
  input  logic       low,
  input  logic       fall,
  input  logic       ack,
  output lane_res_t  res_nxt
);

  logic             held_r, deb_r, pressed_r;
  logic [CNT_W-1:0] cnt_r;
  logic             held_nxt, deb_nxt, pressed_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic             event_nxt;

  always_comb begin
    logic             held0;
    logic             pr0;
    logic [CNT_W-1:0] c_up;
    held0       = held_r | fall;
    pr0         = pressed_r & ~ack;
    c_up        = count_up(cnt_r);
    held_nxt    = held0;
    deb_nxt     = deb_r;
    pressed_nxt = pr0;
    cnt_nxt     = cnt_r;
    event_nxt   = 1'b0;
    if (held0) begin
      if (ctrl.is_special) begin
        // short press on release, long-hold event while still low
        if (cnt_r <= cfg.press_delay) begin
          cnt_nxt = c_up;
        end else if (!low) begin
          if (cnt_r < cfg.long_hold) begin
            pressed_nxt = 1'b1;
          end
          held_nxt = 1'b0;
          deb_nxt  = 1'b0;
          cnt_nxt  = '0;
        end else if (!deb_r) begin
          cnt_nxt = c_up;
          if (c_up >= cfg.long_hold) begin
            deb_nxt   = 1'b1;
            event_nxt = 1'b1;
          end
        end
      end else begin
        cnt_nxt = c_up;
        if (!deb_r && !pr0 && (c_up > cfg.press_delay) && low) begin
          pressed_nxt = 1'b1;
          deb_nxt     = 1'b1;
        end
        if (c_up > cfg.rearm_delay) begin
          if (ctrl.is_repeat && low) begin
            // still held: re-arm once the repeat delay has gone by
            if (c_up > cfg.repeat_delay) begin
              cnt_nxt = '0;
              deb_nxt = 1'b0;
            end
          end else begin
            held_nxt = 1'b0;
            deb_nxt  = 1'b0;
            cnt_nxt  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= 1'b0;
      deb_r     <= 1'b0;
      pressed_r <= 1'b0;
      cnt_r     <= '0;
    end else if (upd) begin
      held_r    <= held_nxt;
      deb_r     <= deb_nxt;
      pressed_r <= pressed_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  assign res_nxt.pressed         = pressed_nxt;
  assign res_nxt.long_hold_event = event_nxt;

endmodule
